// ----- hdl/rangefinder_frame_decoder_core_defines.svh -----
// Assertion macros for the rangefinder frame decoder.
// Used by the top level only; needs clk_i and rst_ni in the using scope.
`ifndef RANGEFINDER_FRAME_DECODER_CORE_DEFINES_SVH
`define RANGEFINDER_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define RFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must never hold outside reset.
`define RFD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define RFD_ASSERT_IMPL(lbl, ante, cons, msg)
`define RFD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hdl/rfd_pkg.sv -----
// Shared types and constants of the rangefinder frame decoder.
// No dependencies; used by every module of the block.
package rfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] FIELD_FIRST = 4'd3;
  localparam logic [3:0] CHECK_POS   = 4'd10;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_E    = 8'h45;
  localparam logic [7:0] ASCII_R    = 8'h52;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_CHECKSUM   = 2'd1,
    STATUS_DEVICE_ERR = 2'd2,
    STATUS_NOT_DIGIT  = 2'd3
  } status_e;

  // One closed frame: its verdict and the six digit values, most significant first.
  typedef struct packed {
    status_e          status;
    logic [5:0][3:0]  digits;
  } frame_rec_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  endfunction

endpackage

// ----- hdl/rfd_front.sv -----
// Front end: counts bytes into frames, sums them, keeps the field bytes
// and classifies each frame at its checksum byte. Depends on rfd_pkg.
module rfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rfd_pkg::frame_rec_t q_rec_o
);

  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] field_q [7];
  logic       accept;
  logic       closing;
  logic [7:0] expect_sum;
  logic       err_match;
  logic       digits_ok;
  logic [2:0] field_idx;

  assign closing  = (pos_q == rfd_pkg::CHECK_POS);
  // Stall only the checksum beat, and only while the queue has no room.
  assign full_o   = closing && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = accept && closing;

  assign field_idx = 3'(pos_q - rfd_pkg::FIELD_FIRST);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      if (closing) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_q + 4'd1;
        sum_d = sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !closing && (pos_q >= rfd_pkg::FIELD_FIRST)) begin
      field_q[field_idx] <= rx_byte_i;
    end
  end

  assign expect_sum = 8'd0 - sum_q;
  assign err_match  = (field_q[0] == rfd_pkg::ASCII_E) &&
                      (field_q[1] == rfd_pkg::ASCII_R) &&
                      (field_q[2] == rfd_pkg::ASCII_R);
  // The decimal point at field byte 3 is not checked.
  assign digits_ok  = rfd_pkg::is_digit(field_q[0]) && rfd_pkg::is_digit(field_q[1]) &&
                      rfd_pkg::is_digit(field_q[2]) && rfd_pkg::is_digit(field_q[4]) &&
                      rfd_pkg::is_digit(field_q[5]) && rfd_pkg::is_digit(field_q[6]);

  always_comb begin
    if (rx_byte_i != expect_sum) begin
      q_rec_o.status = rfd_pkg::STATUS_CHECKSUM;
    end else if (err_match) begin
      q_rec_o.status = rfd_pkg::STATUS_DEVICE_ERR;
    end else if (!digits_ok) begin
      q_rec_o.status = rfd_pkg::STATUS_NOT_DIGIT;
    end else begin
      q_rec_o.status = rfd_pkg::STATUS_OK;
    end
    // ASCII digits carry their value in the low nibble.
    q_rec_o.digits[5] = field_q[0][3:0];
    q_rec_o.digits[4] = field_q[1][3:0];
    q_rec_o.digits[3] = field_q[2][3:0];
    q_rec_o.digits[2] = field_q[4][3:0];
    q_rec_o.digits[1] = field_q[5][3:0];
    q_rec_o.digits[0] = field_q[6][3:0];
  end

endmodule

// ----- hdl/rfd_queue.sv -----
// Short first-in first-out queue of classified frames between front and back.
// Depends on rfd_pkg.
module rfd_queue #(
  parameter int unsigned Depth = rfd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfd_pkg::frame_rec_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output rfd_pkg::frame_rec_t rdata_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rfd_pkg::frame_rec_t mem [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= next_ptr(wr_q);
      if (do_pop)  rd_q <= next_ptr(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= wdata_i;
  end

endmodule

// ----- hdl/rfd_back.sv -----
// Back end: turns a classified frame into a distance in millimeters over
// two stages and holds the result for the consumer. Depends on rfd_pkg.
module rfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  rfd_pkg::frame_rec_t q_rec_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [19:0]         distance_mm_o,
  output logic [1:0]          status_o
);

  logic             s1_v_q, out_v_q;
  logic [9:0]       hi_q, lo_q;
  rfd_pkg::status_e s1_st_q, out_st_q;
  logic [19:0]      dist_q;
  logic             out_ready, s1_ready;
  logic [9:0]       hi_d, lo_d;
  logic [19:0]      dist_d;

  assign out_ready = !out_v_q || pop_i;
  assign s1_ready  = !s1_v_q || out_ready;
  assign q_pop_o   = !q_empty_i && s1_ready;

  // Meters and fraction, each three digits.
  assign hi_d = 10'(q_rec_i.digits[5]) * 10'd100 + 10'(q_rec_i.digits[4]) * 10'd10
              + 10'(q_rec_i.digits[3]);
  assign lo_d = 10'(q_rec_i.digits[2]) * 10'd100 + 10'(q_rec_i.digits[1]) * 10'd10
              + 10'(q_rec_i.digits[0]);

  assign dist_d = (s1_st_q == rfd_pkg::STATUS_OK)
                ? 20'(hi_q) * 20'd1000 + 20'(lo_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_q  <= q_pop_o;
      if (out_ready) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      s1_st_q <= q_rec_i.status;
    end
    if (out_ready && s1_v_q) begin
      dist_q   <= dist_d;
      out_st_q <= s1_st_q;
    end
  end

  assign empty_o       = !out_v_q;
  assign distance_mm_o = dist_q;
  assign status_o      = out_st_q;

endmodule

// ----- hdl/rangefinder_frame_decoder_core.sv -----
// Rangefinder frame decoder, top level.
// Instantiates rfd_front, rfd_queue and rfd_back; depends on rfd_pkg and the defines header.
//
// Input channel: a beat carries one received byte (rx_byte_i) and is taken on a
// rising edge with push high and full low. Bytes are counted into 11-byte
// frames from reset; bytes 0 to 9 are summed and byte 10 is the checksum.
// Output channel: one result per frame (distance_mm_o, status_o), shown while
// empty is low and taken on a rising edge with pop high.
// Throughput: one byte per cycle while full is low, so one result per frame.
// Path of a result: queue write at the edge that takes the checksum byte,
// then the digit-weighting stage, then the distance register.
// Only the checksum beat can be refused: full rises while the frame queue
// (QueueDepth entries) is full, which happens once the consumer stops popping
// and the back stages and the queue have filled up.
// Reset clears the byte counter, the running sum and all valid flags; no
// result is pending after reset.
`include "rangefinder_frame_decoder_core_defines.svh"

module rangefinder_frame_decoder_core #(
  parameter int unsigned QueueDepth = rfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        push,
  output logic        full,
  output logic [19:0] distance_mm_o,
  output logic [1:0]  status_o,
  output logic        empty,
  input  logic        pop
);

  logic                q_push, q_full, q_pop, q_empty;
  rfd_pkg::frame_rec_t q_wdata, q_rdata;

  rfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_byte_i),
    .push_i    (push),
    .full_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_rec_o   (q_wdata)
  );

  rfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  rfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_rec_i       (q_rdata),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .distance_mm_o (distance_mm_o),
    .status_o      (status_o)
  );

  `RFD_ASSERT_NEVER(a_no_push_when_full, q_push && q_full, "frame pushed into full queue")
  `RFD_ASSERT_IMPL(a_stall_only_on_full_queue, full, q_full, "input stalled with queue room")
  `RFD_ASSERT_IMPL(a_error_has_zero_distance, !empty && (status_o != rfd_pkg::STATUS_OK), distance_mm_o == 20'd0, "error result with nonzero distance")

endmodule
